@@ sv/cfp_pkg.sv @@
package cfp_pkg;

   localparam int FRAME_MAX_DEFAULT = 10;

   localparam int BYTE_W   = 8;
   localparam int OFFS_W   = 9;
   localparam int CSR_AW   = 4;
   localparam int CSR_DW   = 32;
   localparam int REQ_DW   = 8;
   localparam int RSP_DW   = 24;
   localparam int RSP_UW   = 2;
   localparam int WINDOW_N = 4;

   localparam logic [BYTE_W-1:0] HEADER_FIRST_RST    = 8'h2C;
   localparam logic [BYTE_W-1:0] HEADER_SECOND_RST   = 8'h12;
   localparam logic [BYTE_W-1:0] END_MARKER_RST      = 8'h5B;
   localparam logic [BYTE_W-1:0] MAGNITUDE_LIMIT_RST = 8'd180;

   localparam logic [BYTE_W-1:0] SIGN_POSITIVE = 8'd1;

   typedef enum logic [1:0] {
      REG_HEADER_FIRST    = 2'd0,
      REG_HEADER_SECOND   = 2'd1,
      REG_END_MARKER      = 2'd2,
      REG_MAGNITUDE_LIMIT = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [BYTE_W-1:0] header_first;
      logic [BYTE_W-1:0] header_second;
      logic [BYTE_W-1:0] end_marker;
      logic [BYTE_W-1:0] magnitude_limit;
   } csr_regs_type;

   function automatic logic [OFFS_W-1:0] signed_mag(input logic [BYTE_W-1:0] sign,
                                                    input logic [BYTE_W-1:0] mag);
      logic [OFFS_W-1:0] m;
      m = {1'b0, mag};
      if (sign == SIGN_POSITIVE) begin
         signed_mag = m;
      end else begin
         signed_mag = OFFS_W'(-m);
      end
   endfunction

endpackage

@@ sv/camera_offset_frame_parser.sv @@
// Channel   Dir  Payload
// req_*     in   tdata[7:0] rx_byte
// rsp_*     out  tdata[8:0] x_offset, [17:9] y_offset; tuser[0] updated, [1] marker end
// csr_*     in   APB, registers at 0x0 0x4 0x8 0xC, pready tied high
//
// A byte can be taken on every clock unless the result register stalls requests.
// The result register holds one frame result; every request stalls while it holds
// a result and rsp_tready is low.
// Synchronous reset clears parse state, held offsets and the result valid.
// Frame end shows on rsp in the cycle after the closing byte is taken.
module camera_offset_frame_parser
   import cfp_pkg::*;
#(
   parameter int FRAME_MAX = FRAME_MAX_DEFAULT
)(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [REQ_DW-1:0] req_tdata,   // [7:0] rx_byte
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [RSP_DW-1:0] rsp_tdata,   // [8:0] x_offset, [17:9] y_offset, rest zero
   output logic [RSP_UW-1:0] rsp_tuser,   // [0] offsets_updated, [1] ended_by_marker
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   csr_regs_type      regs;
   logic [OFFS_W-1:0] rsp_x;
   logic [OFFS_W-1:0] rsp_y;
   logic              rsp_updated;
   logic              rsp_by_marker;

   cfp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .regs        (regs)
   );

   cfp_core #(
      .FRAME_MAX (FRAME_MAX)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .regs          (regs),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_byte      (req_tdata[BYTE_W-1:0]),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_x         (rsp_x),
      .rsp_y         (rsp_y),
      .rsp_updated   (rsp_updated),
      .rsp_by_marker (rsp_by_marker)
   );

   assign rsp_tdata = {{(RSP_DW - 2*OFFS_W){1'b0}}, rsp_y, rsp_x};
   assign rsp_tuser = {rsp_by_marker, rsp_updated};

endmodule

@@ sv/cfp_csr.sv @@
module cfp_csr
   import cfp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready,
   output csr_regs_type      regs
);

   csr_regs_type  regs_ff;
   csr_regs_type  regs_in;
   reg_index_type index;
   logic          write_en;

   assign index    = reg_index_type'(csr_paddr[CSR_AW-1:2]);
   assign write_en = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      regs_in = regs_ff;
      if (write_en) begin
         unique case (index)
            REG_HEADER_FIRST:    regs_in.header_first    = csr_pwdata[BYTE_W-1:0];
            REG_HEADER_SECOND:   regs_in.header_second   = csr_pwdata[BYTE_W-1:0];
            REG_END_MARKER:      regs_in.end_marker      = csr_pwdata[BYTE_W-1:0];
            REG_MAGNITUDE_LIMIT: regs_in.magnitude_limit = csr_pwdata[BYTE_W-1:0];
            default:             regs_in = regs_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.header_first    <= HEADER_FIRST_RST;
         regs_ff.header_second   <= HEADER_SECOND_RST;
         regs_ff.end_marker      <= END_MARKER_RST;
         regs_ff.magnitude_limit <= MAGNITUDE_LIMIT_RST;
      end else begin
         regs_ff <= regs_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (index)
         REG_HEADER_FIRST:    csr_prdata[BYTE_W-1:0] = regs_ff.header_first;
         REG_HEADER_SECOND:   csr_prdata[BYTE_W-1:0] = regs_ff.header_second;
         REG_END_MARKER:      csr_prdata[BYTE_W-1:0] = regs_ff.end_marker;
         REG_MAGNITUDE_LIMIT: csr_prdata[BYTE_W-1:0] = regs_ff.magnitude_limit;
         default:             csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;
   assign regs       = regs_ff;

endmodule

@@ sv/cfp_core.sv @@
module cfp_core
   import cfp_pkg::*;
#(
   parameter int FRAME_MAX = FRAME_MAX_DEFAULT
)(
   input  logic              clock,
   input  logic              reset,
   input  csr_regs_type      regs,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [BYTE_W-1:0] req_byte,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [OFFS_W-1:0] rsp_x,
   output logic [OFFS_W-1:0] rsp_y,
   output logic              rsp_updated,
   output logic              rsp_by_marker
);

   localparam int CNT_W = $clog2(FRAME_MAX + 1);
   localparam logic [CNT_W-1:0] CNT_LAST   = CNT_W'(FRAME_MAX - 1);
   localparam logic [CNT_W-1:0] CNT_WINDOW = CNT_W'(WINDOW_N);
   localparam logic [CNT_W-1:0] CNT_ONE    = CNT_W'(1);
   localparam logic [CNT_W-1:0] CNT_TWO    = CNT_W'(2);

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_HDR1,
      PH_DATA,
      PH_DONE
   } phase_type;

   phase_type         phase_ff, phase_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [BYTE_W-1:0] window_ff [WINDOW_N];
   logic [BYTE_W-1:0] window_in [WINDOW_N];
   logic [OFFS_W-1:0] held_x_ff, held_x_in;
   logic [OFFS_W-1:0] held_y_ff, held_y_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [OFFS_W-1:0] rsp_x_ff, rsp_x_in;
   logic [OFFS_W-1:0] rsp_y_ff, rsp_y_in;
   logic              rsp_updated_ff, rsp_updated_in;
   logic              rsp_marker_ff, rsp_marker_in;

   logic take;
   logic store;
   logic emit;
   logic is_marker;
   logic in_range;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign take       = req_tvalid && req_tready;
   assign is_marker  = (req_byte == regs.end_marker);
   assign in_range   = (count_ff >= CNT_WINDOW)
                    && (window_ff[1] < regs.magnitude_limit)
                    && (window_ff[3] < regs.magnitude_limit);

   always_comb begin
      phase_in       = phase_ff;
      count_in       = count_ff;
      held_x_in      = held_x_ff;
      held_y_in      = held_y_ff;
      store          = 1'b0;
      emit           = 1'b0;
      rsp_x_in       = rsp_x_ff;
      rsp_y_in       = rsp_y_ff;
      rsp_updated_in = rsp_updated_ff;
      rsp_marker_in  = rsp_marker_ff;
      if (take) begin
         unique case (phase_ff)
            PH_IDLE, PH_DONE: begin
               phase_in = PH_IDLE;
               count_in = '0;
               if (req_byte == regs.header_first) begin
                  store    = 1'b1;
                  count_in = CNT_ONE;
                  phase_in = PH_HDR1;
               end
            end
            PH_HDR1: begin
               if (req_byte == regs.header_second) begin
                  store    = 1'b1;
                  count_in = CNT_TWO;
                  phase_in = PH_DATA;
               end else begin
                  count_in = '0;
                  phase_in = PH_IDLE;
               end
            end
            PH_DATA: begin
               store    = 1'b1;
               count_in = count_ff + CNT_ONE;
               if (is_marker || count_ff >= CNT_LAST) begin
                  emit          = 1'b1;
                  phase_in      = PH_DONE;
                  rsp_x_in      = held_x_ff;
                  rsp_y_in      = held_y_ff;
                  rsp_updated_in = in_range;
                  rsp_marker_in = is_marker;
                  if (in_range) begin
                     held_x_in = signed_mag(window_ff[0], window_ff[1]);
                     held_y_in = signed_mag(window_ff[2], window_ff[3]);
                     rsp_x_in  = held_x_in;
                     rsp_y_in  = held_y_in;
                  end
               end
            end
            default: phase_in = PH_IDLE;
         endcase
      end
   end

   always_comb begin
      for (int i = 0; i < WINDOW_N; i++) begin
         window_in[i] = window_ff[i];
      end
      if (store) begin
         for (int i = 0; i < WINDOW_N - 1; i++) begin
            window_in[i] = window_ff[i+1];
         end
         window_in[WINDOW_N-1] = req_byte;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         count_ff     <= '0;
         held_x_ff    <= '0;
         held_y_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         held_x_ff    <= held_x_in;
         held_y_ff    <= held_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      window_ff      <= window_in;
      rsp_x_ff       <= rsp_x_in;
      rsp_y_ff       <= rsp_y_in;
      rsp_updated_ff <= rsp_updated_in;
      rsp_marker_ff  <= rsp_marker_in;
   end

   assign rsp_tvalid    = rsp_valid_ff;
   assign rsp_x         = rsp_x_ff;
   assign rsp_y         = rsp_y_ff;
   assign rsp_updated   = rsp_updated_ff;
   assign rsp_by_marker = rsp_marker_ff;

   a_idle_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |-> count_ff == '0)
      else $error("count not cleared in idle");

   a_data_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |-> (count_ff >= CNT_TWO && count_ff <= CNT_LAST))
      else $error("frame count out of range");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_x_ff == held_x_ff && rsp_y_ff == held_y_ff))
      else $error("pending result disagrees with held offsets");

   a_result_phase: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> phase_ff == PH_DONE)
      else $error("result raised outside frame end");

endmodule
